// File: hdl/sqsw_pkg.sv
package sqsw_pkg;

    localparam int unsigned FREQ_W   = 11;
    localparam int unsigned PERIOD_W = 13;

    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ADDR_SWEEP   = 3'd0,
        ADDR_DUTY    = 3'd1,
        ADDR_ENV     = 3'd2,
        ADDR_FREQ_LO = 3'd3,
        ADDR_FREQ_HI = 3'd4
    } t_addr;

    typedef struct packed {
        logic [1:0] kind;
        logic [2:0] addr;
        logic [7:0] data;
    } t_item;

    typedef struct packed {
        logic [7:0]          read_data;
        logic                channel_on;
        logic [FREQ_W-1:0]   tone_frequency;
        logic [PERIOD_W-1:0] timer_reload;
        logic [1:0]          duty_sel;
        logic [3:0]          level;
    } t_result;

endpackage

// File: hdl/sqsw_sweep_calc.sv
module sqsw_sweep_calc (
    input  logic [sqsw_pkg::FREQ_W-1:0] i_shadow,
    input  logic [2:0]                  i_shift,
    input  logic                        i_down,
    output logic [sqsw_pkg::FREQ_W-1:0] o_next,
    output logic                        o_overflow
);

    logic [sqsw_pkg::FREQ_W-1:0] delta;
    logic [sqsw_pkg::FREQ_W:0]   sum;

    always_comb begin
        delta = i_shadow >> i_shift;
        if (i_down) begin
            sum = {1'b0, i_shadow} - {1'b0, delta};
        end else begin
            sum = {1'b0, i_shadow} + {1'b0, delta};
        end
    end

    assign o_next     = sum[sqsw_pkg::FREQ_W-1:0];
    // anything above 2047 shows up in the carry bit
    assign o_overflow = sum[sqsw_pkg::FREQ_W];

endmodule

// File: hdl/sqsw_regs.sv
module sqsw_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  sqsw_pkg::t_item   i_item,
    output sqsw_pkg::t_result o_result
);

    logic [2:0]                    r_shift, n_shift;
    logic                          r_down, n_down;
    logic [2:0]                    r_pace, n_pace;
    logic [2:0]                    r_count, n_count;
    logic                          r_active, n_active;
    logic                          r_sub, n_sub;
    logic                          r_chan, n_chan;
    logic [1:0]                    r_duty, n_duty;
    logic [2:0]                    r_env_pace, n_env_pace;
    logic                          r_env_up, n_env_up;
    logic [3:0]                    r_env_vol, n_env_vol;
    logic [sqsw_pkg::FREQ_W-1:0]   r_freq, n_freq;
    logic [sqsw_pkg::FREQ_W-1:0]   r_shadow, n_shadow;
    logic [sqsw_pkg::PERIOD_W-1:0] r_period, n_period;
    logic [3:0]                    r_volume, n_volume;
    logic                          r_len_en, n_len_en;

    logic [sqsw_pkg::FREQ_W-1:0]   trig_freq;
    logic [sqsw_pkg::FREQ_W-1:0]   calc_src;
    logic [sqsw_pkg::FREQ_W-1:0]   a_next, b_next;
    logic                          a_ovf, b_ovf;
    logic                          is_trigger;
    logic [2:0]                    count_dec;
    logic                          dac_on;
    logic [7:0]                    rd;

    function automatic logic [sqsw_pkg::PERIOD_W-1:0] reload_of(
        input logic [sqsw_pkg::FREQ_W-1:0] f
    );
        logic [sqsw_pkg::FREQ_W:0] diff;
        diff = 12'd2048 - {1'b0, f};
        return {diff, 1'b0};
    endfunction

    assign trig_freq  = {i_item.data[2:0], r_freq[7:0]};
    assign is_trigger = (i_item.kind == sqsw_pkg::KIND_WRITE)
                     && (i_item.addr == sqsw_pkg::ADDR_FREQ_HI) && i_item.data[7];
    assign calc_src   = is_trigger ? trig_freq : r_shadow;
    assign count_dec  = r_count - 3'd1;
    assign dac_on     = (r_env_vol != 4'd0) || r_env_up;

    // first step: trigger check or tick update; second step: recheck after write-back
    sqsw_sweep_calc u_calc_a (
        .i_shadow   (calc_src),
        .i_shift    (r_shift),
        .i_down     (r_down),
        .o_next     (a_next),
        .o_overflow (a_ovf)
    );

    sqsw_sweep_calc u_calc_b (
        .i_shadow   (a_next),
        .i_shift    (r_shift),
        .i_down     (r_down),
        .o_next     (b_next),
        .o_overflow (b_ovf)
    );

    always_comb begin
        n_shift    = r_shift;
        n_down     = r_down;
        n_pace     = r_pace;
        n_count    = r_count;
        n_active   = r_active;
        n_sub      = r_sub;
        n_chan     = r_chan;
        n_duty     = r_duty;
        n_env_pace = r_env_pace;
        n_env_up   = r_env_up;
        n_env_vol  = r_env_vol;
        n_freq     = r_freq;
        n_shadow   = r_shadow;
        n_period   = r_period;
        n_volume   = r_volume;
        n_len_en   = r_len_en;
        rd         = 8'd0;

        case (i_item.kind)
            sqsw_pkg::KIND_WRITE: begin
                case (i_item.addr)
                    sqsw_pkg::ADDR_SWEEP: begin
                        // leaving subtract mode after a subtraction kills the channel
                        if (r_sub && r_down && !i_item.data[3]) begin
                            n_chan = 1'b0;
                        end
                        n_shift = i_item.data[2:0];
                        n_down  = i_item.data[3];
                        n_pace  = i_item.data[6:4];
                    end
                    sqsw_pkg::ADDR_DUTY: begin
                        n_duty = i_item.data[7:6];
                    end
                    sqsw_pkg::ADDR_ENV: begin
                        n_env_pace = i_item.data[2:0];
                        n_env_up   = i_item.data[3];
                        n_env_vol  = i_item.data[7:4];
                        if (i_item.data[7:4] == 4'd0 && !i_item.data[3]) begin
                            n_chan = 1'b0;
                        end
                    end
                    sqsw_pkg::ADDR_FREQ_LO: begin
                        n_freq = {r_freq[10:8], i_item.data};
                    end
                    sqsw_pkg::ADDR_FREQ_HI: begin
                        n_freq   = trig_freq;
                        n_len_en = i_item.data[6];
                        if (i_item.data[7]) begin
                            n_chan   = dac_on;
                            n_period = reload_of(trig_freq);
                            n_volume = r_env_vol;
                            n_shadow = trig_freq;
                            n_count  = r_pace;
                            n_active = (r_pace != 3'd0) || (r_shift != 3'd0);
                            n_sub    = 1'b0;
                            if (r_shift != 3'd0) begin
                                n_sub = r_down;
                                if (a_ovf) begin
                                    n_chan = 1'b0;
                                end
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end
            sqsw_pkg::KIND_READ: begin
                case (i_item.addr)
                    sqsw_pkg::ADDR_SWEEP:   rd = {1'b0, r_pace, r_down, r_shift};
                    sqsw_pkg::ADDR_DUTY:    rd = {r_duty, 6'd0};
                    sqsw_pkg::ADDR_ENV:     rd = {r_env_vol, r_env_up, r_env_pace};
                    sqsw_pkg::ADDR_FREQ_HI: rd = {1'b0, r_len_en, 6'd0};
                    default:                rd = 8'd0;
                endcase
            end
            sqsw_pkg::KIND_TICK: begin
                if (r_chan && r_pace != 3'd0) begin
                    if (count_dec == 3'd0) begin
                        n_count = r_pace;
                        if (r_active) begin
                            n_sub = r_down;
                            if (a_ovf) begin
                                n_chan = 1'b0;
                            end else if (r_shift != 3'd0) begin
                                n_shadow = a_next;
                                n_freq   = a_next;
                                n_period = reload_of(a_next);
                                if (b_ovf) begin
                                    n_chan = 1'b0;
                                end
                            end
                        end
                    end else begin
                        n_count = count_dec;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift    <= '0;
            r_down     <= 1'b0;
            r_pace     <= '0;
            r_count    <= '0;
            r_active   <= 1'b0;
            r_sub      <= 1'b0;
            r_chan     <= 1'b0;
            r_duty     <= '0;
            r_env_pace <= '0;
            r_env_up   <= 1'b0;
            r_env_vol  <= '0;
            r_freq     <= '0;
            r_shadow   <= '0;
            r_period   <= '0;
            r_volume   <= '0;
            r_len_en   <= 1'b0;
        end else if (i_advance) begin
            r_shift    <= n_shift;
            r_down     <= n_down;
            r_pace     <= n_pace;
            r_count    <= n_count;
            r_active   <= n_active;
            r_sub      <= n_sub;
            r_chan     <= n_chan;
            r_duty     <= n_duty;
            r_env_pace <= n_env_pace;
            r_env_up   <= n_env_up;
            r_env_vol  <= n_env_vol;
            r_freq     <= n_freq;
            r_shadow   <= n_shadow;
            r_period   <= n_period;
            r_volume   <= n_volume;
            r_len_en   <= n_len_en;
        end
    end

    always_comb begin
        o_result.read_data      = rd;
        o_result.channel_on     = n_chan;
        o_result.tone_frequency = n_freq;
        o_result.timer_reload   = n_period;
        o_result.duty_sel       = n_duty;
        o_result.level          = n_volume;
    end

endmodule

// File: hdl/square_channel_sweep_registers.sv
// Each item passes through an input register, then a result register; an output
// stall can hold it in the input register.
// Throughput: one item per cycle unless the output stalls; channel state updates
// as an item moves from the input register into the result register, so the next
// item sees it. Reset (synchronous, active low): all channel state clears to
// zero and both pipeline registers empty.
module square_channel_sweep_registers (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_kind,
    input  logic [2:0]                    i_addr,
    input  logic [7:0]                    i_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [7:0]                    o_read_data,
    output logic                          o_channel_on,
    output logic [sqsw_pkg::FREQ_W-1:0]   o_tone_frequency,
    output logic [sqsw_pkg::PERIOD_W-1:0] o_timer_reload,
    output logic [1:0]                    o_duty_sel,
    output logic [3:0]                    o_level
);

    logic              r_in_valid;
    sqsw_pkg::t_item   r_item;
    logic              r_out_valid;
    sqsw_pkg::t_result r_result;
    sqsw_pkg::t_result n_result;
    logic              advance;
    logic              in_xfer;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    sqsw_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_item),
        .o_result  (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_item.kind <= i_kind;
            r_item.addr <= i_addr;
            r_item.data <= i_data;
        end
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_read_data      = r_result.read_data;
    assign o_channel_on     = r_result.channel_on;
    assign o_tone_frequency = r_result.tone_frequency;
    assign o_timer_reload   = r_result.timer_reload;
    assign o_duty_sel       = r_result.duty_sel;
    assign o_level          = r_result.level;

endmodule
